>>> rtl/sjf_pkg.sv
// Shared types and constants for the shortest-job-first scheduler.
package sjf_pkg;

  localparam int MAX_JOBS_DEF = 64;
  localparam int ARR_W        = 16;
  localparam int LEN_W        = 16;
  localparam int JOB_IDX_W    = 6;
  localparam int TIME_W       = 23;
  localparam logic [TIME_W-1:0] TIME_TOP = 23'd4259775;

  // One job as it is loaded.
  typedef struct packed {
    logic [ARR_W-1:0] arrive_at;
    logic [LEN_W-1:0] job_length;
    logic             final_job;
  } in_item_t;

  // One completion report.
  typedef struct packed {
    logic [JOB_IDX_W-1:0] job_index;
    logic [TIME_W-1:0]    done_time;
    logic [TIME_W-1:0]    turnaround;
    logic                 end_of_run;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic scan_clr;
    logic scan_issue;
    logic commit;
    logic jump;
    logic clear_run;
  } sjf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_final;
    logic scan_last;
    logic found;
    logic run_last;
    logic out_free;
  } sjf_stat_t;

endpackage

>>> rtl/sjf_ctrl.sv
// Controller state machine: loading, scanning and choosing the next job.
module sjf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sjf_pkg::sjf_stat_t stat,
  output sjf_pkg::sjf_cmd_t  cmd
);
  import sjf_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Jobs are only taken while loading.
  assign in_stall = (state != S_LOAD);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.store = 1'b1;
          if (stat.in_final) begin
            cmd.scan_clr = 1'b1;
            state_next   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.found) begin
          if (stat.out_free) begin
            cmd.commit = 1'b1;
            if (stat.run_last) begin
              cmd.clear_run = 1'b1;
              state_next    = S_LOAD;
            end else begin
              cmd.scan_clr = 1'b1;
              state_next   = S_SCAN;
            end
          end
        end else begin
          // Nothing has arrived: move the clock on and look again.
          cmd.jump     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

>>> rtl/sjf_dp.sv
// Datapath: job stores, scan pipeline, scheduler clock and output register.
module sjf_dp #(
  parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sjf_pkg::in_item_t  in_item,
  input  sjf_pkg::sjf_cmd_t  cmd,
  output sjf_pkg::sjf_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output sjf_pkg::out_item_t out_item
);
  import sjf_pkg::*;

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  logic [ARR_W-1:0]    arrival_mem [MAX_JOBS];
  logic [LEN_W-1:0]    length_mem  [MAX_JOBS];
  logic [MAX_JOBS-1:0] finished;
  logic [CNT_W-1:0]    job_count;
  logic [CNT_W-1:0]    done_count;
  logic [TIME_W-1:0]   clock_now;

  logic [IDX_W-1:0]    scan_idx;
  logic                p_vld;
  logic [IDX_W-1:0]    p_idx;
  logic [ARR_W-1:0]    rd_arr;
  logic [LEN_W-1:0]    rd_len;

  logic                found;
  logic [IDX_W-1:0]    best_idx;
  logic [LEN_W-1:0]    best_len;
  logic [ARR_W-1:0]    best_arr;
  logic [ARR_W-1:0]    earliest;

  logic                room;
  logic                p_live;
  logic                p_arrived;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   done_time;
  logic [TIME_W-1:0]   turn;

  assign room      = (job_count < CNT_W'(MAX_JOBS));
  assign p_live    = p_vld && !finished[p_idx];
  assign p_arrived = ({{(TIME_W-ARR_W){1'b0}}, rd_arr} <= clock_now);

  // Finish time of the chosen job, saturated at the top of the range.
  assign sum       = {1'b0, clock_now} + {{(TIME_W+1-LEN_W){1'b0}}, best_len};
  assign done_time = (sum > {1'b0, TIME_TOP}) ? TIME_TOP : sum[TIME_W-1:0];
  assign turn      = done_time - {{(TIME_W-ARR_W){1'b0}}, best_arr};

  // Status back to the controller.
  assign stat.in_final  = in_item.final_job;
  assign stat.scan_last = ({{(CNT_W-IDX_W){1'b0}}, scan_idx} + CNT_W'(1)) == job_count;
  assign stat.found     = found;
  assign stat.run_last  = (done_count + CNT_W'(1)) == job_count;
  assign stat.out_free  = !out_valid || !out_stall;

  // Job stores: one write port while loading, one registered read while scanning.
  always_ff @(posedge clk) begin
    if (cmd.store && room) begin
      arrival_mem[job_count[IDX_W-1:0]] <= in_item.arrive_at;
      length_mem[job_count[IDX_W-1:0]]  <= in_item.job_length;
    end
    if (cmd.scan_issue) begin
      rd_arr <= arrival_mem[scan_idx];
      rd_len <= length_mem[scan_idx];
    end
  end

  // Run bookkeeping: job and completion counts, clock and finished flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_count  <= '0;
      done_count <= '0;
      clock_now  <= '0;
      finished   <= '0;
    end else if (cmd.clear_run) begin
      job_count  <= '0;
      done_count <= '0;
      clock_now  <= '0;
      finished   <= '0;
    end else begin
      if (cmd.store && room) begin
        job_count <= job_count + CNT_W'(1);
      end
      if (cmd.jump) begin
        clock_now <= {{(TIME_W-ARR_W){1'b0}}, earliest};
      end
      if (cmd.commit) begin
        clock_now          <= done_time;
        finished[best_idx] <= 1'b1;
        done_count         <= done_count + CNT_W'(1);
      end
    end
  end

  // Scan address and read pipeline valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      p_vld    <= 1'b0;
    end else begin
      p_vld <= cmd.scan_issue;
      if (cmd.scan_clr) begin
        scan_idx <= '0;
      end else if (cmd.scan_issue) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      p_idx <= scan_idx;
    end
  end

  // Running choice: least burst among arrived jobs, first index on ties,
  // and the earliest arrival among the unfinished ones.
  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      earliest <= '1;
    end else if (cmd.scan_clr) begin
      found    <= 1'b0;
      earliest <= '1;
    end else if (p_live) begin
      if (p_arrived && (!found || rd_len < best_len)) begin
        found <= 1'b1;
      end
      if (rd_arr < earliest) begin
        earliest <= rd_arr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_live && p_arrived && (!found || rd_len < best_len)) begin
      best_idx <= p_idx;
      best_len <= rd_len;
      best_arr <= rd_arr;
    end
  end

  // Output register: holds one report until the receiver takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item.job_index  <= JOB_IDX_W'(best_idx);
      out_item.done_time  <= done_time;
      out_item.turnaround <= turn;
      out_item.end_of_run <= stat.run_last;
    end
  end

endmodule

>>> rtl/sjf_nonpreemptive_schedule_top.sv
// Top level of the non-preemptive shortest-job-first scheduler.
//
// Jobs come in on the input channel (in_valid / in_stall / in_item), one
// beat per job, each with its arrival tick and burst length. A beat with
// final_job set closes the set; jobs beyond MAX_JOBS are dropped. While a
// set is loading every beat is taken in the cycle it is offered.
// After the final beat the block schedules from tick zero. Each choice is
// one pass over the N stored jobs through the single read port of the job
// stores; when no job has arrived yet the clock jumps to the earliest
// pending arrival and a second pass follows. Reports leave on the output
// channel (out_valid / out_stall / out_item) in completion order, one beat
// per job, with end_of_run set on the last one.
// The output register holds a report while the receiver stalls; the next
// choice is then computed but waits until the register is free. The next
// set is taken as soon as the last report is in the output register.
// Reset empties the job set and the output register; the block then waits
// for the first job.
module sjf_nonpreemptive_schedule_top #(
  parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sjf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sjf_pkg::out_item_t out_item
);
  import sjf_pkg::*;

  sjf_cmd_t  cmd;
  sjf_stat_t stat;

  // Sequencing of load, scan and choice.
  sjf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores, scan and result datapath.
  sjf_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> verif/tb_sjf_nonpreemptive_schedule_top.sv
// Self-checking testbench for the non-preemptive shortest-job-first scheduler.
module tb_sjf_nonpreemptive_schedule_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sjf_pkg::*;

  localparam int JOB_SLOTS   = MAX_JOBS_DEF;
  localparam int QUIET_LIMIT = 5000;
  localparam int END_SLACK   = 300;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Model of the job set being loaded and the reports still owed.
  logic [ARR_W-1:0] set_arrive [JOB_SLOTS];
  logic [LEN_W-1:0] set_length [JOB_SLOTS];
  int               set_size = 0;
  out_item_t        pending_reports[$];

  int error_count  = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  sjf_nonpreemptive_schedule_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Store an accepted job and, on the final one, run the whole schedule and queue
  // one report per job in completion order.
  task automatic plan_schedule(input in_item_t job);
    int unsigned now;
    int unsigned best;
    int unsigned earliest;
    int unsigned span;
    int          pick;
    int          finished;
    bit          done_flag [JOB_SLOTS];
    out_item_t   rpt;
    if (set_size < JOB_SLOTS) begin
      set_arrive[set_size] = job.arrive_at;
      set_length[set_size] = job.job_length;
      set_size++;
    end
    if (!job.final_job) return;
    now = 0;
    finished = 0;
    foreach (done_flag[i]) done_flag[i] = 1'b0;
    while (finished < set_size) begin
      pick = -1;
      best = 0;
      for (int i = 0; i < set_size; i++) begin
        if (!done_flag[i] && set_arrive[i] <= now && (pick < 0 || set_length[i] < best)) begin
          pick = i;
          best = set_length[i];
        end
      end
      if (pick < 0) begin
        // Nothing has arrived yet: move the clock to the earliest pending arrival.
        earliest = 32'hFFFF_FFFF;
        for (int i = 0; i < set_size; i++) begin
          if (!done_flag[i] && set_arrive[i] < earliest) earliest = set_arrive[i];
        end
        now = earliest;
      end else begin
        now = now + set_length[pick];
        if (now > TIME_TOP) now = TIME_TOP;
        done_flag[pick] = 1'b1;
        finished++;
        span = now - set_arrive[pick];
        rpt.job_index  = pick[JOB_IDX_W-1:0];
        rpt.done_time  = now[TIME_W-1:0];
        rpt.turnaround = span[TIME_W-1:0];
        rpt.end_of_run = (finished == set_size);
        pending_reports.push_back(rpt);
      end
    end
    set_size = 0;
  endtask

  // Offer one job beat, with random idle cycles ahead of it, and wait for it to be taken.
  task automatic send_job(input in_item_t job);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= job;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    plan_schedule(job);
  endtask

  task automatic send_fields(input int arrive, input int length, input bit last);
    in_item_t job;
    job.arrive_at  = ARR_W'(arrive);
    job.job_length = LEN_W'(length);
    job.final_job  = last;
    send_job(job);
  endtask

  // Hold the sender back until every owed report has been received.
  task automatic drain_reports();
    if (pending_reports.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clk);
    end
  endtask

  // Single-job sets at the corners of the field ranges.
  task automatic test_single_jobs();
    send_fields(0, 0, 1'b1);
    send_fields(65535, 65535, 1'b1);
    send_fields(0, 65535, 1'b1);
    send_fields(65535, 0, 1'b1);
    drain_reports();
  endtask

  // Equal bursts resolve to the lower index; a shorter late arrival goes first.
  task automatic test_ties_and_order();
    send_fields(0, 8, 1'b0);
    send_fields(1, 3, 1'b0);
    send_fields(2, 3, 1'b0);
    send_fields(2, 1, 1'b0);
    send_fields(0, 8, 1'b1);
    drain_reports();
  endtask

  // Idle stretches where the clock has to jump ahead, with zero-length jobs mixed in.
  task automatic test_idle_jumps();
    send_fields(10, 4, 1'b0);
    send_fields(3, 0, 1'b0);
    send_fields(50, 2, 1'b0);
    send_fields(50, 2, 1'b0);
    send_fields(51, 1, 1'b0);
    send_fields(5, 0, 1'b0);
    send_fields(5, 0, 1'b1);
    drain_reports();
  endtask

  // A full store of the longest, latest jobs: finish times reach the top of the range.
  // The final beat arrives with the store full and is dropped, yet starts the run.
  task automatic test_full_store();
    for (int j = 0; j < JOB_SLOTS; j++) send_fields(65535, 65535, 1'b0);
    send_fields(1, 1, 1'b1);
    drain_reports();
  endtask

  // Overfull set with random content: extra beats are dropped silently.
  task automatic test_overfull_set();
    for (int j = 0; j < JOB_SLOTS + 1; j++) begin
      send_fields($urandom_range(400), $urandom_range(300), 1'b0);
    end
    send_fields($urandom_range(65535), $urandom_range(65535), 1'b1);
    drain_reports();
  endtask

  // Random sets, mostly small, with arrival and burst windows chosen per set.
  task automatic run_random_sets(input int n_jobs);
    int sent;
    int size;
    int arr_span;
    int len_span;
    sent = 0;
    while (sent < n_jobs) begin
      if ($urandom_range(99) < 15) drain_reports();
      case ($urandom_range(19))
        0:             size = $urandom_range(21, JOB_SLOTS + 2);
        1, 2, 3, 4, 5: size = $urandom_range(7, 20);
        default:       size = $urandom_range(1, 6);
      endcase
      case ($urandom_range(2))
        0:       arr_span = 15;
        1:       arr_span = 300;
        default: arr_span = 65535;
      endcase
      case ($urandom_range(2))
        0:       len_span = 7;
        1:       len_span = 200;
        default: len_span = 65535;
      endcase
      for (int j = 0; j < size; j++) begin
        send_fields($urandom_range(arr_span),
                    ($urandom_range(9) == 0) ? 0 : $urandom_range(len_span),
                    j == size - 1);
      end
      sent += size;
    end
  endtask

  // Random traffic under each idling pattern of sender and receiver.
  task automatic test_random_traffic();
    send_idle_pct = 0;  stall_pct = 0;  run_random_sets(40);
    drain_reports();
    send_idle_pct = 68; stall_pct = 0;  run_random_sets(40);
    send_idle_pct = 0;  stall_pct = 68; run_random_sets(40);
    send_idle_pct = 37; stall_pct = 37; run_random_sets(40);
  endtask

  // Compare each report beat with the oldest one owed; choose the next stall at random.
  always @(posedge clk) begin : report_check
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected report: job_index %0d done_time %0d",
                 out_item.job_index, out_item.done_time);
          error_count++;
        end else begin
          want = pending_reports.pop_front();
          if (out_item.job_index !== want.job_index) begin
            $error("job_index: expected %0d, got %0d", want.job_index, out_item.job_index);
            error_count++;
          end
          if (out_item.done_time !== want.done_time) begin
            $error("done_time: expected %0d, got %0d", want.done_time, out_item.done_time);
            error_count++;
          end
          if (out_item.turnaround !== want.turnaround) begin
            $error("turnaround: expected %0d, got %0d", want.turnaround, out_item.turnaround);
            error_count++;
          end
          if (out_item.end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %0d, got %0d", want.end_of_run, out_item.end_of_run);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $error("no beat accepted for %0d cycles, %0d reports owed",
           QUIET_LIMIT, pending_reports.size());
    $display("TB_ERROR");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_single_jobs();
    test_ties_and_order();
    test_idle_jumps();
    test_full_store();
    test_overfull_set();
    test_random_traffic();
    drain_reports();
    repeat (END_SLACK) @(posedge clk);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
